// ----- sv/ipv4hc_pkg.sv -----
`default_nettype none
package ipv4hc_pkg;

  localparam int unsigned MinHeaderBytes = 20;
  localparam logic [3:0]  IpVersionFour  = 4'd4;
  localparam logic [3:0]  MinIhl         = 4'd5;
  localparam logic [15:0] SumAllOnes     = 16'hFFFF;
  localparam logic [15:0] PosMax         = 16'hFFFF;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // byte offsets inside the header
  localparam logic [15:0] PosVerIhl   = 16'd0;
  localparam logic [15:0] PosLenHi    = 16'd2;
  localparam logic [15:0] PosLenLo    = 16'd3;
  localparam logic [15:0] PosProto    = 16'd9;
  localparam logic [15:0] PosSrcFirst = 16'd12;
  localparam logic [15:0] PosDstFirst = 16'd16;
  localparam logic [15:0] PosDstEnd   = 16'd20;

  typedef enum logic [3:0] {
    StIcmp        = 4'd0,
    StUdp         = 4'd1,
    StTcp         = 4'd2,
    StTooShort    = 4'd3,
    StNotIpv4     = 4'd4,
    StBadIhl      = 4'd5,
    StBadChecksum = 4'd6,
    StNotForUs    = 4'd7,
    StUnknown     = 4'd8
  } status_e;

  // header fields as they stand after the current byte
  typedef struct packed {
    logic [15:0] pos;
    logic [7:0]  version_and_ihl;
    logic [15:0] stated_len;
    logic [7:0]  protocol;
    logic [31:0] sender_address;
    logic [31:0] target_address;
    logic [15:0] ones_sum;
  } snapshot_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  protocol;
    logic [5:0]  header_length;
    logic [15:0] payload_length;
    logic [31:0] source_address;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/ipv4hc_in_if.sv -----
`default_nettype none
interface ipv4hc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/ipv4hc_out_if.sv -----
`default_nettype none
interface ipv4hc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  protocol;
  logic [5:0]  header_length;
  logic [15:0] payload_length;
  logic [31:0] source_address;

  modport source (output valid, output status, output protocol, output header_length,
                  output payload_length, output source_address, input ready);
  modport sink   (input valid, input status, input protocol, input header_length,
                  input payload_length, input source_address, output ready);
endinterface
`default_nettype wire

// ----- sv/ipv4hc_cfg_if.sv -----
`default_nettype none
interface ipv4hc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/ipv4hc_parse.sv -----
`default_nettype none
module ipv4hc_parse (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  last_byte_i,
  output ipv4hc_pkg::snapshot_t      snap_o
);
  import ipv4hc_pkg::*;

  logic [15:0] pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  vi_q, vi_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic [5:0]  hdr_bytes;
  logic [16:0] raw_sum;
  logic [15:0] folded_sum;

  always_comb begin
    vi_d    = (pos_q == PosVerIhl) ? data_byte_i : vi_q;
    len_d   = len_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    held_d  = held_q;
    sum_d   = sum_q;

    if (pos_q == PosLenHi) len_d[15:8] = data_byte_i;
    if (pos_q == PosLenLo) len_d[7:0]  = data_byte_i;
    if (pos_q == PosProto) proto_d     = data_byte_i;
    if (pos_q >= PosSrcFirst && pos_q < PosDstFirst) src_d = {src_q[23:0], data_byte_i};
    if (pos_q >= PosDstFirst && pos_q < PosDstEnd)   dst_d = {dst_q[23:0], data_byte_i};

    // IHL of this very byte counts when it is the first one
    hdr_bytes  = {vi_d[3:0], 2'b00};
    raw_sum    = {1'b0, sum_q} + {1'b0, held_q, data_byte_i};
    folded_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};

    if (pos_q < {10'd0, hdr_bytes}) begin
      if (!pos_q[0]) held_d = data_byte_i;
      else           sum_d  = folded_sum;
    end
  end

  assign snap_o = '{pos:             pos_q,
                    version_and_ihl: vi_d,
                    stated_len:      len_d,
                    protocol:        proto_d,
                    sender_address:  src_d,
                    target_address:  dst_d,
                    ones_sum:        sum_d};

  assign pos_d = (pos_q == PosMax) ? pos_q : pos_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      held_q  <= '0;
      vi_q    <= '0;
      len_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        // packet done: start the next one from a clean slate
        pos_q   <= '0;
        sum_q   <= '0;
        held_q  <= '0;
        vi_q    <= '0;
        len_q   <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        held_q  <= held_d;
        vi_q    <= vi_d;
        len_q   <= len_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/ipv4hc_verdict.sv -----
`default_nettype none
module ipv4hc_verdict (
  input  wire ipv4hc_pkg::snapshot_t snap_i,
  input  wire logic [31:0]           local_address_i,
  output ipv4hc_pkg::result_t        result_o
);
  import ipv4hc_pkg::*;

  logic [3:0]  ihl;
  logic [5:0]  hdr_bytes;
  logic [16:0] count;
  status_e     status;

  always_comb begin
    ihl       = snap_i.version_and_ihl[3:0];
    hdr_bytes = {ihl, 2'b00};
    count     = {1'b0, snap_i.pos} + 17'd1;

    if (count < 17'(MinHeaderBytes))                       status = StTooShort;
    else if (snap_i.version_and_ihl[7:4] != IpVersionFour) status = StNotIpv4;
    else if (ihl < MinIhl)                                 status = StBadIhl;
    else if (count < {11'd0, hdr_bytes})                   status = StTooShort;
    else if (snap_i.ones_sum != SumAllOnes)                status = StBadChecksum;
    else if (snap_i.target_address != local_address_i)     status = StNotForUs;
    else begin
      case (snap_i.protocol)
        ProtoIcmp: status = StIcmp;
        ProtoUdp:  status = StUdp;
        ProtoTcp:  status = StTcp;
        default:   status = StUnknown;
      endcase
    end

    result_o.status         = status;
    result_o.protocol       = snap_i.protocol;
    result_o.header_length  = hdr_bytes;
    // saturate at zero when the stated length is below the header length
    result_o.payload_length = (snap_i.stated_len > {10'd0, hdr_bytes})
                              ? snap_i.stated_len - {10'd0, hdr_bytes} : 16'd0;
    result_o.source_address = snap_i.sender_address;
  end

endmodule
`default_nettype wire

// ----- sv/ipv4hc_out_reg.sv -----
`default_nettype none
module ipv4hc_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire ipv4hc_pkg::result_t result_i,
  output logic                     space_o,
  ipv4hc_out_if.source             out_o
);
  import ipv4hc_pkg::*;

  logic    valid_q;
  result_t data_q;

  // room for a new item when empty or when the held one leaves this cycle
  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= result_i;
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = data_q.status;
  assign out_o.protocol       = data_q.protocol;
  assign out_o.header_length  = data_q.header_length;
  assign out_o.payload_length = data_q.payload_length;
  assign out_o.source_address = data_q.source_address;

endmodule
`default_nettype wire

// ----- sv/ipv4_rx_header_check.sv -----
`default_nettype none
// channel | dir | payload                                         | handshake
// --------+-----+-------------------------------------------------+-------------
// in_i    | in  | data_byte[7:0], last_byte                       | valid/ready
// out_o   | out | status, protocol, header_length, payload_length,| valid/ready
//         |     | source_address                                  |
// cfg_i   | in  | data[31:0] = local_address                      | valid/ready
//
// One byte is taken every cycle unless in_i stalls; the verdict appears on out_o in
// the cycle after the last byte is taken: that byte and the header field registers
// feed the checksum fold and verdict logic, whose result is held in the result register.
// Reset clears all per-packet state and the local address to zero.
// in_i stalls only while a result is held and out_o is not ready; cfg_i never stalls.
module ipv4_rx_header_check (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ipv4hc_in_if.sink    in_i,
  ipv4hc_out_if.source out_o,
  ipv4hc_cfg_if.sink   cfg_i
);
  import ipv4hc_pkg::*;

  logic [31:0] local_address_q;
  logic        accept;
  logic        space;
  snapshot_t   snap;
  result_t     result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_address_q <= '0;
    end else if (cfg_i.valid) begin
      local_address_q <= cfg_i.data;
    end
  end

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  ipv4hc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .snap_o      (snap)
  );

  ipv4hc_verdict u_verdict (
    .snap_i          (snap),
    .local_address_i (local_address_q),
    .result_o        (result)
  );

  ipv4hc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept && in_i.last_byte),
    .result_i (result),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire

// ----- dv/ipv4_rx_header_check_test.sv -----
`default_nettype none
module ipv4_rx_header_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4hc_pkg::*;

  localparam int unsigned CycleLimit = 60_000;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned TailCycles = 8;

  logic clk_i;
  logic rst_ni;

  ipv4hc_in_if  byte_ch ();
  ipv4hc_out_if verdict_ch ();
  ipv4hc_cfg_if addr_ch ();

  ipv4_rx_header_check dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (verdict_ch),
    .cfg_i  (addr_ch)
  );

  // header tracker mirroring the block, advanced on every accepted byte
  logic [15:0] rx_pos      = '0;
  logic [15:0] rx_sum      = '0;
  logic [7:0]  rx_high     = '0;
  logic [7:0]  rx_ver_ihl  = '0;
  logic [15:0] rx_total    = '0;
  logic [7:0]  rx_proto    = '0;
  logic [31:0] rx_src      = '0;
  logic [31:0] rx_dst      = '0;
  logic [31:0] own_address = '0;

  result_t     verdict_q[$];
  logic [7:0]  frame_q[$];

  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  bit          in_gaps_on    = 1'b1;
  bit          out_gaps_on   = 1'b1;
  bit          hold_off_pending = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ones'-complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[16] ? s[15:0] + 16'd1 : s[15:0];
  endfunction

  // advance the tracker by one byte; returns 1 with the verdict on the final byte
  function automatic bit absorb_byte(input logic [7:0] b, input logic is_last,
                                     output result_t r);
    logic [5:0]  hlen;
    logic [16:0] seen;
    r = '0;
    if (rx_pos == PosVerIhl) rx_ver_ihl = b;
    else if (rx_pos == PosLenHi) rx_total[15:8] = b;
    else if (rx_pos == PosLenLo) rx_total[7:0] = b;
    else if (rx_pos == PosProto) rx_proto = b;
    else if (rx_pos >= PosSrcFirst && rx_pos < PosDstFirst) rx_src = {rx_src[23:0], b};
    else if (rx_pos >= PosDstFirst && rx_pos < PosDstEnd) rx_dst = {rx_dst[23:0], b};

    hlen = {rx_ver_ihl[3:0], 2'b00};
    if (rx_pos < {10'd0, hlen}) begin
      if (!rx_pos[0]) rx_high = b;
      else rx_sum = fold_add(rx_sum, {rx_high, b});
    end
    seen = {1'b0, rx_pos} + 17'd1;
    if (rx_pos != PosMax) rx_pos = rx_pos + 16'd1;
    if (!is_last) return 1'b0;

    if (seen < MinHeaderBytes) r.status = StTooShort;
    else if (rx_ver_ihl[7:4] != IpVersionFour) r.status = StNotIpv4;
    else if (rx_ver_ihl[3:0] < MinIhl) r.status = StBadIhl;
    else if (seen < {11'd0, hlen}) r.status = StTooShort;
    else if (rx_sum != SumAllOnes) r.status = StBadChecksum;
    else if (rx_dst != own_address) r.status = StNotForUs;
    else if (rx_proto == ProtoIcmp) r.status = StIcmp;
    else if (rx_proto == ProtoUdp) r.status = StUdp;
    else if (rx_proto == ProtoTcp) r.status = StTcp;
    else r.status = StUnknown;
    r.protocol       = rx_proto;
    r.header_length  = hlen;
    r.payload_length = (rx_total > {10'd0, hlen}) ? rx_total - {10'd0, hlen} : 16'd0;
    r.source_address = rx_src;

    rx_pos = '0; rx_sum = '0; rx_high = '0; rx_ver_ihl = '0;
    rx_total = '0; rx_proto = '0; rx_src = '0; rx_dst = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // compare each verdict taken, then predict from each byte taken at this edge
  always @(posedge clk_i) begin
    result_t want;
    result_t fresh;
    if (rst_ni) begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict 0x%0h arrived with none pending", $time, verdict_ch.status);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 32'(want.status), 32'(verdict_ch.status));
          check_field("protocol", 32'(want.protocol), 32'(verdict_ch.protocol));
          check_field("header_length", 32'(want.header_length),
                      32'(verdict_ch.header_length));
          check_field("payload_length", 32'(want.payload_length),
                      32'(verdict_ch.payload_length));
          check_field("source_address", want.source_address, verdict_ch.source_address);
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        if (absorb_byte(byte_ch.data_byte, byte_ch.last_byte, fresh))
          verdict_q.push_back(fresh);
      end
    end
  end

  // receiver: random stall before each verdict, long hold-off on request
  initial begin
    int stall;
    verdict_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = out_gaps_on ? $urandom_range(0, 7) : 0;
      if (hold_off_pending) begin
        stall = LongHold;
        hold_off_pending = 1'b0;
      end
      if (stall > 0) begin
        verdict_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      verdict_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!verdict_ch.valid);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= is_last;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      push_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // header with a correct checksum over its IHL words, then random payload
  task automatic build_frame(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] tot, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst,
                             input int pay);
    int hlen;
    int span;
    logic [15:0] acc;
    hlen = int'(ihl) * 4;
    span = (hlen < 20) ? 20 : hlen;
    frame_q.delete();
    repeat (span + pay) frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q[0]  = {ver, ihl};
    frame_q[2]  = tot[15:8];
    frame_q[3]  = tot[7:0];
    frame_q[9]  = proto;
    frame_q[10] = 8'h00;
    frame_q[11] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      frame_q[12 + i] = src[31 - 8 * i -: 8];
      frame_q[16 + i] = dst[31 - 8 * i -: 8];
    end
    acc = 16'h0000;
    for (int i = 0; i + 1 < hlen; i += 2) acc = fold_add(acc, {frame_q[i], frame_q[i + 1]});
    acc = ~acc;
    frame_q[10] = acc[15:8];
    frame_q[11] = acc[7:0];
  endtask

  task automatic trim_frame(input int keep);
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endtask

  // drop valid, drain every pending verdict, then let the pipeline empty
  task automatic settle_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic set_local_address(input logic [31:0] addr);
    settle_idle();
    addr_ch.valid <= 1'b1;
    addr_ch.data  <= addr;
    do @(posedge clk_i); while (!addr_ch.ready);
    own_address = addr;
    addr_ch.valid <= 1'b0;
  endtask

  task automatic test_directed_frames();
    // local address is still zero from reset
    build_frame(4'd4, 4'd5, 16'd20, ProtoIcmp, 32'h0, 32'h0, 0);
    send_frame();
    build_frame(4'd4, 4'd15, 16'hFFFF, ProtoUdp, 32'hFFFF_FFFF, 32'h0, 2);
    send_frame();
    // total length below header length: payload saturates at zero
    build_frame(4'd4, 4'd5, 16'd0, ProtoTcp, 32'h0A00_0001, 32'h0, 4);
    send_frame();
    build_frame(4'd4, 4'd5, 16'd24, 8'd0, 32'hC0A8_0001, 32'h0, 4);
    send_frame();
    build_frame(4'd4, 4'd5, 16'd21, 8'hFF, 32'h8000_0000, 32'h0, 1);
    send_frame();
    // one-byte frame and a frame one byte short of a minimal header
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    build_frame(4'd4, 4'd5, 16'd20, ProtoUdp, 32'h1234_5678, 32'h0, 0);
    trim_frame(19);
    send_frame();
    // long enough for a minimal header but shorter than its IHL
    build_frame(4'd4, 4'd15, 16'd60, ProtoTcp, 32'h0102_0304, 32'h0, 0);
    trim_frame(40);
    send_frame();
    build_frame(4'd6, 4'd5, 16'd20, ProtoTcp, 32'h0, 32'h0, 0);
    send_frame();
    frame_q.delete();
    repeat (20) frame_q.push_back(8'h00);
    send_frame();
    build_frame(4'd15, 4'd15, 16'd60, ProtoUdp, 32'h0, 32'h0, 0);
    send_frame();
    build_frame(4'd4, 4'd4, 16'd20, ProtoIcmp, 32'h0, 32'h0, 0);
    send_frame();
    build_frame(4'd4, 4'd0, 16'd20, ProtoIcmp, 32'h0, 32'h0, 3);
    send_frame();
    build_frame(4'd4, 4'd5, 16'd20, ProtoIcmp, 32'h0, 32'h0, 0);
    frame_q[12] ^= 8'h01;
    send_frame();
    build_frame(4'd4, 4'd5, 16'd20, ProtoIcmp, 32'h0, 32'h0102_0304, 0);
    send_frame();
    set_local_address(32'hFFFF_FFFF);
    build_frame(4'd4, 4'd5, 16'd28, ProtoIcmp, 32'h7F00_0001, 32'hFFFF_FFFF, 8);
    send_frame();
    build_frame(4'd4, 4'd5, 16'd28, ProtoIcmp, 32'h7F00_0001, 32'h0, 8);
    send_frame();
  endtask

  task automatic test_address_settings();
    logic [31:0] addrs[4];
    addrs = '{32'h0000_0000, 32'h0A00_0001, 32'hFFFF_FFFF, $urandom};
    foreach (addrs[k]) begin
      set_local_address(addrs[k]);
      build_frame(4'd4, 4'd5, 16'd22, ProtoUdp, $urandom, addrs[k], 2);
      send_frame();
      build_frame(4'd4, 4'd5, 16'd22, ProtoUdp, $urandom, addrs[k] ^ 32'h1, 2);
      send_frame();
      build_frame(4'd4, 4'd6, 16'd24, ProtoTcp, $urandom, ~addrs[k], 0);
      send_frame();
    end
  endtask

  // hold the verdict output while bytes keep coming, so the input stalls
  task automatic test_output_backpressure();
    settle_idle();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    hold_off_pending = 1'b1;
    repeat (8) begin
      build_frame(4'd4, 4'd5, 16'd23, ProtoTcp, $urandom, own_address, 3);
      send_frame();
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int kind;
    int pay;
    int phase_bytes;
    int phase_frames;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tot;
    logic [7:0]  proto;
    logic [31:0] dst;
    for (int phase = 0; phase < 4; phase++) begin
      set_local_address($urandom);
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < 60 || phase_frames < 3) begin
        if ($urandom_range(0, 9) == 0) in_gaps_on = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) == 0) out_gaps_on = ($urandom_range(0, 2) != 0);
        kind = $urandom_range(0, 99);
        ver  = 4'd4;
        ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        pay  = $urandom_range(0, 12);
        tot  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(int'(ihl) * 4 + pay);
        case ($urandom_range(0, 3))
          0: proto = ProtoIcmp;
          1: proto = ProtoUdp;
          2: proto = ProtoTcp;
          default: proto = 8'($urandom);
        endcase
        dst = own_address;
        if (kind >= 65 && kind < 71) dst = own_address ^ (32'h1 << $urandom_range(0, 31));
        if (kind >= 77 && kind < 82) ver = 4'($urandom_range(0, 15));
        if (kind >= 82 && kind < 87) ihl = 4'($urandom_range(0, 4));
        build_frame(ver, ihl, tot, proto, $urandom, dst, pay);
        if (kind >= 71 && kind < 77)
          frame_q[$urandom_range(4, int'(ihl) * 4 - 1)] ^= 8'(1 << $urandom_range(0, 7));
        else if (kind >= 87 && kind < 93)
          trim_frame($urandom_range(1, frame_q.size() - 1));
        else if (kind >= 93) begin
          frame_q.delete();
          repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        phase_bytes += frame_q.size();
        phase_frames++;
        send_frame();
      end
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    addr_ch.valid     <= 1'b0;
    addr_ch.data      <= 32'h0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_address_settings();
    test_output_backpressure();
    test_random_traffic();
    settle_idle();

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
